/* hw/rtl/lmp_pkg.sv */
// Shared types, constants and saturating fixed-point helpers for the momentum push.
`default_nettype none
package lmp_pkg;

    localparam int LMP_WORD_W    = 32;
    localparam int LMP_FRAC_BITS = 16;
    localparam int LMP_IW        = 64;

    typedef logic signed [LMP_WORD_W-1:0] t_word;
    typedef logic signed [LMP_IW-1:0]     t_int;
    typedef logic [LMP_IW-1:0]            t_uint;
    typedef logic [2:0][LMP_IW-1:0]       t_vec;

    typedef struct packed {
        t_word momentum_x;
        t_word momentum_y;
        t_word momentum_z;
        t_word efield_x;
        t_word efield_y;
        t_word efield_z;
        t_word bfield_x;
        t_word bfield_y;
        t_word bfield_z;
    } t_in_beat;

    typedef struct packed {
        t_word new_momentum_x;
        t_word new_momentum_y;
        t_word new_momentum_z;
        t_word delta_momentum_x;
        t_word delta_momentum_y;
        t_word delta_momentum_z;
    } t_out_beat;

    localparam t_int LMP_MAX  = t_int'({1'b0, {(LMP_IW-1){1'b1}}});
    localparam t_int LMP_MIN  = ~LMP_MAX;
    localparam t_int LMP_WMAX = t_int'({1'b0, {(LMP_WORD_W-1){1'b1}}});
    localparam t_int LMP_WMIN = ~LMP_WMAX;

    function automatic t_int lmp_sext(input t_word w);
        return t_int'(w);
    endfunction

    function automatic t_uint lmp_mag(input t_int x);
        return x[LMP_IW-1] ? t_uint'(-x) : t_uint'(x);
    endfunction

    function automatic t_int lmp_from_mag(input t_uint m, input logic neg);
        if (neg) begin
            if (m[LMP_IW-1]) begin
                return LMP_MIN;
            end
            return t_int'(-m);
        end
        if (m[LMP_IW-1]) begin
            return LMP_MAX;
        end
        return t_int'(m);
    endfunction

    function automatic t_int lmp_sat_add(input t_int a, input t_int b);
        logic [LMP_IW:0] s;
        s = {a[LMP_IW-1], a} + {b[LMP_IW-1], b};
        if (s[LMP_IW] != s[LMP_IW-1]) begin
            return s[LMP_IW] ? LMP_MIN : LMP_MAX;
        end
        return t_int'(s[LMP_IW-1:0]);
    endfunction

    function automatic t_int lmp_sat_sub(input t_int a, input t_int b);
        logic [LMP_IW:0] s;
        s = {a[LMP_IW-1], a} - {b[LMP_IW-1], b};
        if (s[LMP_IW] != s[LMP_IW-1]) begin
            return s[LMP_IW] ? LMP_MIN : LMP_MAX;
        end
        return t_int'(s[LMP_IW-1:0]);
    endfunction

    function automatic t_word lmp_clamp(input t_int v);
        if (v > LMP_WMAX) begin
            return t_word'(LMP_WMAX);
        end
        if (v < LMP_WMIN) begin
            return t_word'(LMP_WMIN);
        end
        return t_word'(v);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lmp_dly.sv */
// Enable-gated delay line that keeps operands aligned with the arithmetic pipeline.
`default_nettype none
module lmp_dly #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);
    if (DEPTH == 0) begin : g_none
        assign o_d = i_d;
    end else begin : g_line
        logic [WIDTH-1:0] r_tap [DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tap[0] <= i_d;
                for (int k = 1; k < DEPTH; k++) begin
                    r_tap[k] <= r_tap[k-1];
                end
            end
        end
        assign o_d = r_tap[DEPTH-1];
    end
endmodule
`default_nettype wire

/* hw/rtl/lmp_mul.sv */
// Three-stage saturating signed fixed-point multiplier built from 32x32 partial products.
`default_nettype none
module lmp_mul #(
    parameter int FRAC_BITS = lmp_pkg::LMP_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  lmp_pkg::t_int i_a,
    input  lmp_pkg::t_int i_b,
    output lmp_pkg::t_int o_p
);
    import lmp_pkg::*;

    t_uint       r_ma;
    t_uint       r_mb;
    logic        r_neg1;
    logic        r_neg2;
    logic [63:0] r_ll;
    logic [63:0] r_lh;
    logic [63:0] r_hl;
    logic [63:0] r_hh;
    logic [127:0] prod;
    logic [127:0] shd;
    t_uint       mag_v;

    always_comb begin
        prod  = {r_hh, 64'd0} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0} + {64'd0, r_ll};
        shd   = prod >> FRAC_BITS;
        mag_v = (|shd[127:64]) ? '1 : shd[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= lmp_mag(i_a);
            r_mb   <= lmp_mag(i_b);
            r_neg1 <= i_a[LMP_IW-1] ^ i_b[LMP_IW-1];
            r_ll   <= r_ma[31:0] * r_mb[31:0];
            r_lh   <= r_ma[31:0] * r_mb[63:32];
            r_hl   <= r_ma[63:32] * r_mb[31:0];
            r_hh   <= r_ma[63:32] * r_mb[63:32];
            r_neg2 <= r_neg1;
            o_p    <= lmp_from_mag(mag_v, r_neg2);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/lmp_sqrt.sv */
// Pipelined floor square root, two radicand bits per stage.
`default_nettype none
module lmp_sqrt #(
    parameter int FRAC_BITS = lmp_pkg::LMP_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  lmp_pkg::t_int i_x,
    output lmp_pkg::t_int o_r
);
    import lmp_pkg::*;

    localparam int STEPS = (LMP_IW + FRAC_BITS + 1) / 2;
    localparam int AW    = 2 * STEPS;
    localparam int EW    = STEPS + 2;

    logic [AW-1:0]    r_arg  [STEPS+1];
    logic [EW-1:0]    r_rem  [STEPS+1];
    logic [STEPS-1:0] r_root [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg[0]  <= (i_x[LMP_IW-1] || i_x == '0) ? '0 :
                         AW'({i_x[LMP_IW-2:0], FRAC_BITS'(0)});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [EW-1:0] cur;
        logic [EW-1:0] trial;
        logic          ge;
        always_comb begin
            cur   = {r_rem[g][EW-3:0], r_arg[g][AW-1:AW-2]};
            trial = {r_root[g], 2'b01};
            ge    = cur >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_arg[g+1]  <= r_arg[g] << 2;
                r_rem[g+1]  <= ge ? cur - trial : cur;
                r_root[g+1] <= {r_root[g][STEPS-2:0], ge};
            end
        end
    end

    assign o_r = t_int'(r_root[STEPS]);
endmodule
`default_nettype wire

/* hw/rtl/lmp_div.sv */
// Pipelined saturating fixed-point divider, one restoring quotient bit per stage.
`default_nettype none
module lmp_div #(
    parameter int FRAC_BITS = lmp_pkg::LMP_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  lmp_pkg::t_int i_a,
    input  lmp_pkg::t_int i_b,
    output lmp_pkg::t_int o_q
);
    import lmp_pkg::*;

    localparam int NW    = LMP_IW + FRAC_BITS;
    localparam int STEPS = NW;

    t_uint         r_rem  [STEPS+1];
    t_uint         r_q    [STEPS+1];
    logic          r_ovf  [STEPS+1];
    logic [NW-1:0] r_num  [STEPS+1];
    t_uint         r_d    [STEPS+1];
    logic          r_neg  [STEPS+1];
    logic          r_zero [STEPS+1];
    logic          r_aneg [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_ovf[0]  <= 1'b0;
            r_num[0]  <= {lmp_mag(i_a), FRAC_BITS'(0)};
            r_d[0]    <= lmp_mag(i_b);
            r_neg[0]  <= i_a[LMP_IW-1] ^ i_b[LMP_IW-1];
            r_zero[0] <= (i_b == '0);
            r_aneg[0] <= i_a[LMP_IW-1];
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [LMP_IW:0] trial;
        logic [LMP_IW:0] diff;
        logic            ge;
        always_comb begin
            trial = {r_rem[g], r_num[g][NW-1]};
            diff  = trial - {1'b0, r_d[g]};
            ge    = trial >= {1'b0, r_d[g]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= ge ? diff[LMP_IW-1:0] : trial[LMP_IW-1:0];
                r_q[g+1]    <= {r_q[g][LMP_IW-2:0], ge};
                r_ovf[g+1]  <= r_ovf[g] | r_q[g][LMP_IW-1];
                r_num[g+1]  <= r_num[g] << 1;
                r_d[g+1]    <= r_d[g];
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
                r_aneg[g+1] <= r_aneg[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[STEPS]) begin
                o_q <= r_aneg[STEPS] ? LMP_MIN : LMP_MAX;
            end else begin
                o_q <= lmp_from_mag(r_ovf[STEPS] ? '1 : r_q[STEPS], r_neg[STEPS]);
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/relativistic_lorentz_momentum_push_core.sv */
// Relativistic Vay momentum push: fully pipelined, one particle per beat.
// The path from input beat to result beat is set by the chain of three pipelined
//   dividers (FRAC_BITS + 66 stages each), two square roots on the path
//   (FRAC_BITS/2 + 33 stages each) and three-stage multipliers.
// Throughput: one beat per cycle; a stall on the output freezes the whole pipeline.
// Reset clears the valid bits and the force scale register (zero).
`default_nettype none
module relativistic_lorentz_momentum_push_core #(
    parameter int FRAC_BITS = lmp_pkg::LMP_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lmp_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output lmp_pkg::t_out_beat o_data,
    input  logic              i_cfg_we,
    input  lmp_pkg::t_word    i_cfg_data
);
    import lmp_pkg::*;

    localparam int ML  = 3;
    localparam int QL  = (LMP_IW + FRAC_BITS + 1) / 2 + 1;
    localparam int DL  = LMP_IW + FRAC_BITS + 2;
    localparam int T1  = ML + 3 + QL + DL;
    localparam int T2  = T1 + ML + 2;
    localparam int T3  = T2 + ML + 4;
    localparam int RT  = T3 + 2 * ML + 2 + QL;
    localparam int GT  = RT + 1 + DL;
    localparam int SST = GT + ML + 1 + DL;
    localparam int LT  = GT + QL + ML;
    localparam int PT  = (LT + 2 > SST) ? LT + 2 : SST;
    localparam int LAT = PT + ML + 1;
    localparam int VW  = 3 * LMP_IW;

    localparam t_int ONE  = t_int'(1) <<< FRAC_BITS;
    localparam t_int TWO  = ONE <<< 1;
    localparam t_int FOUR = ONE <<< 2;

    logic         adv;
    logic [LAT:0] r_vld;
    t_int         r_h;

    t_vec r_p, r_e, r_b;
    t_vec pp, xa0, xb0, eh, tb, tq;
    t_vec p_m, pxb_d, u1_d, eh_d, tau1, pc;
    t_vec uu, ut, ya, yb, tau2, tk, uxt_d, xs, tk_d, upr_d, sb_d, pv, p_d;
    t_vec r_pxb, r_u1, r_u2, r_upr, r_uxt, r_sa, r_xs, r_sb;
    t_int r_s1, r_pp2, r_s2, r_s3, r_tt1, r_tq2, r_tt;
    t_int g0, cc;
    t_int r_uu1, r_uu2, r_ut1, r_ut2, r_uu, r_ut, r_sg1, r_ut_b, r_sigma, r_ut_c;
    t_int tt_d1, tt_d2, tt_d3, ss, ww, ss_d, f4, root, sigma_d, ig2, it, ut_d, kk, sg, s_q, s_d;
    t_int r_q1, r_rad, r_sr, r_den;
    t_out_beat r_out;

    assign adv     = !r_vld[LAT] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_h   <= '0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[LAT-1:0], i_valid};
            end
            if (i_cfg_we) begin
                r_h <= lmp_from_mag(lmp_mag(lmp_sext(i_cfg_data)) >> 1,
                                    i_cfg_data[LMP_WORD_W-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= lmp_sext(i_data.momentum_x);
            r_p[1] <= lmp_sext(i_data.momentum_y);
            r_p[2] <= lmp_sext(i_data.momentum_z);
            r_e[0] <= lmp_sext(i_data.efield_x);
            r_e[1] <= lmp_sext(i_data.efield_y);
            r_e[2] <= lmp_sext(i_data.efield_z);
            r_b[0] <= lmp_sext(i_data.bfield_x);
            r_b[1] <= lmp_sext(i_data.bfield_y);
            r_b[2] <= lmp_sext(i_data.bfield_z);
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_front
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_pp (
            .i_clk, .i_en(adv), .i_a(r_p[gi]), .i_b(r_p[gi]), .o_p(pp[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_xa (
            .i_clk, .i_en(adv), .i_a(r_p[J]), .i_b(r_b[K]), .o_p(xa0[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_xb (
            .i_clk, .i_en(adv), .i_a(r_p[K]), .i_b(r_b[J]), .o_p(xb0[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_eh (
            .i_clk, .i_en(adv), .i_a(r_e[gi]), .i_b(r_h), .o_p(eh[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_tb (
            .i_clk, .i_en(adv), .i_a(r_b[gi]), .i_b(r_h), .o_p(tb[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_tq (
            .i_clk, .i_en(adv), .i_a(tb[gi]), .i_b(tb[gi]), .o_p(tq[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_pc (
            .i_clk, .i_en(adv), .i_a(pxb_d[gi]), .i_b(cc), .o_p(pc[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_uu (
            .i_clk, .i_en(adv), .i_a(r_upr[gi]), .i_b(r_upr[gi]), .o_p(uu[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_ut (
            .i_clk, .i_en(adv), .i_a(r_upr[gi]), .i_b(tau1[gi]), .o_p(ut[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_ya (
            .i_clk, .i_en(adv), .i_a(r_upr[J]), .i_b(tau1[K]), .o_p(ya[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_yb (
            .i_clk, .i_en(adv), .i_a(r_upr[K]), .i_b(tau1[J]), .o_p(yb[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_tk (
            .i_clk, .i_en(adv), .i_a(tau2[gi]), .i_b(kk), .o_p(tk[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_xs (
            .i_clk, .i_en(adv), .i_a(uxt_d[gi]), .i_b(sg), .o_p(xs[gi]));
        lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_pv (
            .i_clk, .i_en(adv), .i_a(sb_d[gi]), .i_b(s_d), .o_p(pv[gi]));
    end

    lmp_dly #(.WIDTH(VW), .DEPTH(ML)) u_dly_pm (
        .i_clk, .i_en(adv), .i_d(r_p), .o_d(p_m));
    lmp_dly #(.WIDTH(VW), .DEPTH(T1 - ML - 1)) u_dly_pxb (
        .i_clk, .i_en(adv), .i_d(r_pxb), .o_d(pxb_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(T1 - 1)) u_dly_u1 (
        .i_clk, .i_en(adv), .i_d(r_u1), .o_d(u1_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(T1 + 1)) u_dly_eh (
        .i_clk, .i_en(adv), .i_d(eh), .o_d(eh_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(T2 - ML)) u_dly_tau1 (
        .i_clk, .i_en(adv), .i_d(tb), .o_d(tau1));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(T2 - ML + 1)) u_dly_tt1 (
        .i_clk, .i_en(adv), .i_d(r_tt), .o_d(tt_d1));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(T3 - ML - 2)) u_dly_tt2 (
        .i_clk, .i_en(adv), .i_d(r_tt), .o_d(tt_d2));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(ML + 1)) u_dly_ss (
        .i_clk, .i_en(adv), .i_d(ss), .o_d(ss_d));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(RT - T3)) u_dly_sigma (
        .i_clk, .i_en(adv), .i_d(r_sigma), .o_d(sigma_d));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(GT - 2 * ML - 2)) u_dly_tt3 (
        .i_clk, .i_en(adv), .i_d(r_tt), .o_d(tt_d3));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(GT - T3)) u_dly_ut (
        .i_clk, .i_en(adv), .i_d(r_ut_c), .o_d(ut_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(GT)) u_dly_tau2 (
        .i_clk, .i_en(adv), .i_d(tb), .o_d(tau2));
    lmp_dly #(.WIDTH(VW), .DEPTH(GT + QL - T2 - ML - 1)) u_dly_uxt (
        .i_clk, .i_en(adv), .i_d(r_uxt), .o_d(uxt_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(QL - ML)) u_dly_tk (
        .i_clk, .i_en(adv), .i_d(tk), .o_d(tk_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(LT - T2)) u_dly_upr (
        .i_clk, .i_en(adv), .i_d(r_upr), .o_d(upr_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(PT - LT - 2)) u_dly_sb (
        .i_clk, .i_en(adv), .i_d(r_sb), .o_d(sb_d));
    lmp_dly #(.WIDTH(LMP_IW), .DEPTH(PT - SST)) u_dly_s (
        .i_clk, .i_en(adv), .i_d(s_q), .o_d(s_d));
    lmp_dly #(.WIDTH(VW), .DEPTH(PT + ML)) u_dly_p (
        .i_clk, .i_en(adv), .i_d(r_p), .o_d(p_d));

    lmp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_g0 (
        .i_clk, .i_en(adv), .i_x(r_s3), .o_r(g0));
    lmp_div #(.FRAC_BITS(FRAC_BITS)) u_div_c (
        .i_clk, .i_en(adv), .i_a(r_h), .i_b(g0), .o_q(cc));
    lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ss (
        .i_clk, .i_en(adv), .i_a(r_sigma), .i_b(r_sigma), .o_p(ss));
    lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ww (
        .i_clk, .i_en(adv), .i_a(r_ut_c), .i_b(r_ut_c), .o_p(ww));
    lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f4 (
        .i_clk, .i_en(adv), .i_a(FOUR), .i_b(r_q1), .o_p(f4));
    lmp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_root (
        .i_clk, .i_en(adv), .i_x(r_rad), .o_r(root));
    lmp_div #(.FRAC_BITS(FRAC_BITS)) u_div_ig2 (
        .i_clk, .i_en(adv), .i_a(TWO), .i_b(r_sr), .o_q(ig2));
    lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_it (
        .i_clk, .i_en(adv), .i_a(ig2), .i_b(tt_d3), .o_p(it));
    lmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k (
        .i_clk, .i_en(adv), .i_a(ut_d), .i_b(ig2), .o_p(kk));
    lmp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_sg (
        .i_clk, .i_en(adv), .i_x(ig2), .o_r(sg));
    lmp_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .i_clk, .i_en(adv), .i_a(ONE), .i_b(r_den), .o_q(s_q));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1  <= lmp_sat_add(pp[0], pp[1]);
            r_pp2 <= pp[2];
            r_s2  <= lmp_sat_add(r_s1, r_pp2);
            r_s3  <= lmp_sat_add(ONE, r_s2);
            r_tt1 <= lmp_sat_add(tq[0], tq[1]);
            r_tq2 <= tq[2];
            r_tt  <= lmp_sat_add(r_tt1, r_tq2);
            for (int i = 0; i < 3; i++) begin
                r_pxb[i] <= lmp_sat_sub(xa0[i], xb0[i]);
                r_u1[i]  <= lmp_sat_add(p_m[i], eh[i]);
                r_u2[i]  <= lmp_sat_add(u1_d[i], pc[i]);
                r_upr[i] <= lmp_sat_add(r_u2[i], eh_d[i]);
                r_uxt[i] <= lmp_sat_sub(ya[i], yb[i]);
                r_sa[i]  <= lmp_sat_add(upr_d[i], tk_d[i]);
                r_xs[i]  <= xs[i];
                r_sb[i]  <= lmp_sat_add(r_sa[i], r_xs[i]);
            end
            r_uu1   <= lmp_sat_add(uu[0], uu[1]);
            r_uu2   <= uu[2];
            r_ut1   <= lmp_sat_add(ut[0], ut[1]);
            r_ut2   <= ut[2];
            r_uu    <= lmp_sat_add(r_uu1, r_uu2);
            r_ut    <= lmp_sat_add(r_ut1, r_ut2);
            r_sg1   <= lmp_sat_add(ONE, r_uu);
            r_ut_b  <= r_ut;
            r_sigma <= lmp_sat_sub(r_sg1, tt_d1);
            r_ut_c  <= r_ut_b;
            r_q1    <= lmp_sat_add(tt_d2, ww);
            r_rad   <= lmp_sat_add(ss_d, f4);
            r_sr    <= lmp_sat_add(sigma_d, root);
            r_den   <= lmp_sat_add(ONE, it);
            r_out.new_momentum_x   <= lmp_clamp(pv[0]);
            r_out.new_momentum_y   <= lmp_clamp(pv[1]);
            r_out.new_momentum_z   <= lmp_clamp(pv[2]);
            r_out.delta_momentum_x <= lmp_clamp(lmp_sat_sub(pv[0], p_d[0]));
            r_out.delta_momentum_y <= lmp_clamp(lmp_sat_sub(pv[1], p_d[1]));
            r_out.delta_momentum_z <= lmp_clamp(lmp_sat_sub(pv[2], p_d[2]));
        end
    end
endmodule
`default_nettype wire
